// File: design/kvt_pkg.sv
// kvt_pkg: shared types and constants of the key/value message tokenizer
// no dependencies; imported by every design file of the block
package kvt_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int PLEN_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_PREFIX_LEN = 1'b0;
    localparam logic [PLEN_W-1:0] PREFIX_RESET = 3'd3;

    // token kinds, also used as the parse phase
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_AUTH  = 2'd1;
    localparam logic [1:0] KIND_KEY   = 2'd2;
    localparam logic [1:0] KIND_VALUE = 2'd3;

    // name match progress against "mcp"
    localparam logic [2:0] MATCH_FULL = 3'd3;
    localparam logic [2:0] MATCH_FAIL = 3'd7;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    typedef struct packed {
        logic [2:0] prefix_count;
        logic [1:0] token_phase;
        logic       in_quote;
        logic       escape_pending;
        logic       colon_seen;
        logic       between_tokens;
        logic [2:0] name_match_pos;
        logic       line_stopped;
    } t_state;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic [1:0] token_kind;
        logic       token_end;
        logic       initial_message;
        logic       parse_error;
    } t_result;

    typedef struct packed {
        t_state  st;
        logic    hit;
        t_result res;
    } t_step;

    function automatic logic [7:0] name_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h6d; // m
            2'd1:    c = 8'h63; // c
            default: c = 8'h70; // p
        endcase
        return c;
    endfunction

endpackage

// File: design/kvt_regs.sv
// kvt_regs: apb-style configuration register (prefix length)
// depends on kvt_pkg
module kvt_regs
    import kvt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [PLEN_W-1:0] o_prefix_length
);

    logic [PLEN_W-1:0] r_prefix_length;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_length <= PREFIX_RESET;
        end else if (wr_en && paddr[2] == REG_PREFIX_LEN) begin
            r_prefix_length <= pwdata[PLEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_PREFIX_LEN) begin
            prdata = {{(DATA_W-PLEN_W){1'b0}}, r_prefix_length};
        end
    end

    assign o_prefix_length = r_prefix_length;

endmodule

// File: design/kvt_step.sv
// kvt_step: next-state and result logic for one line byte
// depends on kvt_pkg
module kvt_step
    import kvt_pkg::*;
(
    input  t_state            i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    input  logic [PLEN_W-1:0] i_prefix_length,
    output t_step             o_step
);

    function automatic logic is_initial(input t_state s);
        return (s.token_phase != KIND_NAME) && (s.name_match_pos == MATCH_FULL);
    endfunction

    function automatic t_step close_tok(input t_state s);
        t_step c;
        logic  init;
        c = '0;
        c.st = s;
        c.st.between_tokens = 1'b1;
        c.st.escape_pending = 1'b0;
        c.st.in_quote = 1'b0;
        c.hit = 1'b1;
        c.res.token_end = 1'b1;
        c.res.token_kind = s.token_phase;
        case (s.token_phase)
            KIND_NAME: begin
                init = (s.name_match_pos == MATCH_FULL);
                c.st.token_phase = init ? KIND_KEY : KIND_AUTH;
                c.res.initial_message = init;
            end
            KIND_KEY: begin
                if (!s.colon_seen) begin
                    c.st.line_stopped = 1'b1;
                    c.res.parse_error = 1'b1;
                end else begin
                    c.st.colon_seen = 1'b0;
                    c.st.token_phase = KIND_VALUE;
                end
                c.res.initial_message = is_initial(c.st);
            end
            default: begin
                c.st.token_phase = KIND_KEY;
                c.st.colon_seen = 1'b0;
                c.res.initial_message = is_initial(c.st);
            end
        endcase
        return c;
    endfunction

    function automatic t_step emit(input t_state s, input logic [7:0] b);
        t_step      c;
        logic [7:0] ch;
        c = '0;
        c.st = s;
        ch = b;
        if (s.token_phase == KIND_NAME) begin
            if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
                ch = b + CASE_SHIFT;
            end
            if (s.name_match_pos < MATCH_FULL && ch == name_char(s.name_match_pos[1:0])) begin
                c.st.name_match_pos = s.name_match_pos + 3'd1;
            end else begin
                c.st.name_match_pos = MATCH_FAIL;
            end
        end
        c.hit = 1'b1;
        c.res.token_byte = ch;
        c.res.byte_valid = 1'b1;
        c.res.token_kind = s.token_phase;
        c.res.initial_message = is_initial(c.st);
        return c;
    endfunction

    t_state t;

    always_comb begin
        o_step = '0;
        o_step.st = i_state;
        t = i_state;
        if (i_end) begin
            if (!i_state.line_stopped && i_state.prefix_count >= i_prefix_length
                    && !i_state.between_tokens) begin
                o_step = close_tok(i_state);
            end
            // line state starts over after every line end
            o_step.st = '0;
        end else if (i_state.line_stopped) begin
            o_step.st = i_state;
        end else if (i_state.prefix_count < i_prefix_length) begin
            o_step.st.prefix_count = i_state.prefix_count + 3'd1;
        end else if ((i_byte == CH_SPACE || i_byte == CH_NL) && !i_state.in_quote) begin
            t.escape_pending = 1'b0;
            o_step.st = t;
            if (!i_state.between_tokens) begin
                o_step = close_tok(t);
            end
        end else begin
            t.between_tokens = 1'b0;
            o_step.st = t;
            if (i_byte == CH_QUOTE) begin
                if (i_state.escape_pending) begin
                    t.escape_pending = 1'b0;
                    o_step = emit(t, i_byte);
                end else begin
                    o_step.st.in_quote = !i_state.in_quote;
                end
            end else if (i_byte == CH_BSLASH) begin
                if (i_state.escape_pending) begin
                    t.escape_pending = 1'b0;
                    o_step = emit(t, i_byte);
                end else begin
                    o_step.st.escape_pending = 1'b1;
                end
            end else begin
                t.escape_pending = 1'b0;
                o_step.st = t;
                if (i_byte == CH_COLON && !i_state.in_quote) begin
                    // bare colon only marks a key, never emitted
                    if (i_state.token_phase == KIND_KEY) begin
                        o_step.st.colon_seen = 1'b1;
                    end
                end else begin
                    o_step = emit(t, i_byte);
                end
            end
        end
    end

endmodule

// File: design/kvt_pipe.sv
// kvt_pipe: input register, parser state and result register around kvt_step
// depends on kvt_pkg and kvt_step
module kvt_pipe
    import kvt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PLEN_W-1:0] i_prefix_length,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_line_byte,
    input  logic              i_line_end,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_result           o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    t_state     r_state;
    logic       r_out_valid;
    t_result    r_out;
    t_step      step;
    logic       advance;
    logic       take;

    kvt_step u_step (
        .i_state         (r_state),
        .i_byte          (r_in_byte),
        .i_end           (r_in_end),
        .i_prefix_length (i_prefix_length),
        .o_step          (step)
    );

    // the held request moves on when the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign take       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= step.hit;
                r_state     <= step.st;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_line_byte;
            r_in_end  <= i_line_end;
        end
        if (advance) begin
            r_out <= step.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    a_err_is_key_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.parse_error |-> r_out.token_end && r_out.token_kind == KIND_KEY)
        else $error("parse error on a result that is not a key end mark");

    a_hit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step.hit |=> r_out_valid)
        else $error("result of a request was lost");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line_stopped && !(advance && r_in_end) |=> r_state.line_stopped)
        else $error("stopped line resumed without a line end");

    a_byte_or_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.byte_valid && r_out.token_end))
        else $error("result carries both a character and an end mark");

endmodule

// File: design/keyvalue_message_tokenizer_top.sv
// keyvalue_message_tokenizer_top: line tokenizer with its configuration port
// depends on kvt_pkg, kvt_regs and kvt_pipe
//
// Takes one line byte (or a line end) per request and gives zero or one token
// result for it, in order: a character with its kind, or an end mark. One
// request is accepted every clock while the output side is not stalled; the
// single-pass step logic between the input register and the result register
// sets this, and each request's result is held in the result register for output.
// The prefix length register is written over the apb port at byte address 0
// and should only be changed while no request is in flight.
module keyvalue_message_tokenizer_top
    import kvt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_line_byte,
    input  logic              i_line_end,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_token_byte,
    output logic              o_byte_valid,
    output logic [1:0]        o_token_kind,
    output logic              o_token_end,
    output logic              o_initial_message,
    output logic              o_parse_error
);

    logic [PLEN_W-1:0] prefix_length;
    t_result           res;

    kvt_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_prefix_length (prefix_length)
    );

    kvt_pipe u_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_prefix_length (prefix_length),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_line_byte     (i_line_byte),
        .i_line_end      (i_line_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_res           (res)
    );

    assign o_token_byte      = res.token_byte;
    assign o_byte_valid      = res.byte_valid;
    assign o_token_kind      = res.token_kind;
    assign o_token_end       = res.token_end;
    assign o_initial_message = res.initial_message;
    assign o_parse_error     = res.parse_error;

endmodule
